[hw/rtl/ppde_pkg.sv]
// Package for the piecewise polynomial derivative evaluator.
// Field widths, command and status codes, shared structs and fixed-point helpers.
// No dependencies.
package ppde_pkg;

    localparam int NUM_POINTS_DEF = 256;
    localparam int MAX_ORDER_DEF  = 7;

    localparam int WORD_W  = 32;
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 11;
    localparam int PORD_W  = 3;
    localparam int DORD_W  = 3;
    localparam int PCNT_W  = 9;
    localparam int IVL_W   = 8;
    localparam int STAT_W  = 2;
    localparam int FF_W    = 32;
    localparam int FF_D    = 2 ** DORD_W;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 64;
    localparam int RND_W   = 48;

    localparam int S_TDATA_W  = 80;
    localparam int S_TUSER_W  = CMD_W;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = STAT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PCNT_W;

    localparam logic [CMD_W-1:0] CMD_LOAD_BP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_CF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL    = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DERIV = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POLY_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd2;

    localparam logic [PORD_W-1:0] POLY_ORDER_RST  = 3'd3;
    localparam logic [DORD_W-1:0] DERIV_ORDER_RST = 3'd0;
    localparam logic [PCNT_W-1:0] POINT_COUNT_RST = 9'd256;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] ONE_Q16  = 32'h0001_0000;

    localparam logic signed [ACC_W:0] ACC_POS = 65'sh0_4000_0000_0000_0000;
    localparam logic signed [ACC_W:0] ACC_NEG = -ACC_POS;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot_index;
        logic [WORD_W-1:0] load_value;
        logic [WORD_W-1:0] query_point;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [IVL_W-1:0]  interval_used;
        logic [STAT_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [PORD_W-1:0] poly_order;
        logic [DORD_W-1:0] deriv_order;
        logic [PCNT_W-1:0] point_count;
    } cfg_t;

    typedef struct packed {
        logic              bp_we;
        logic              cf_we;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    // floor((v + 2^15) / 2^16) on a Q32.32 product; |v| <= 2^62 so no wrap
    function automatic logic [RND_W-1:0] rnd16(input logic [ACC_W-1:0] v);
        logic [ACC_W-1:0] w;
        w = v + 64'd32768;
        return w[ACC_W-1:16];
    endfunction

    function automatic logic sat32_ovf(input logic [RND_W-1:0] v);
        return !((&v[RND_W-1:WORD_W-1]) || !(|v[RND_W-1:WORD_W-1]));
    endfunction

    function automatic logic [WORD_W-1:0] sat32_val(input logic [RND_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (sat32_ovf(v))
            r = v[RND_W-1] ? WORD_MIN : WORD_MAX;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    // falling factorial j*(j-1)*...*(j-d+1), elaboration only
    function automatic longint ff_calc(input int j, input int d);
        longint r;
        r = 1;
        for (int k = 0; k < d; k++)
            r = r * longint'(j - k);
        return r;
    endfunction

endpackage

[hw/rtl/piecewise_poly_derivative_eval_top.sv]
// Top level of the piecewise polynomial derivative evaluator.
// Stream ports, configuration registers and output register.
// Depends on ppde_pkg and ppde_core.
//
// Usage:
//   s_axis carries command words: tuser is the command (load breakpoint,
//   load coefficient, evaluate); tdata holds slot index, load value and query
//   point. m_axis carries one result word per evaluate command.
//   cfg_* writes polynomial order, derivative order and point count; write
//   only while no evaluate is in flight. cfg_ready is always high.
// Sequencing:
//   A load word is written as it is taken; the next word can follow right after.
//   An evaluate word scans all n breakpoints through the breakpoint memory
//   read port, then runs the load, power, coefficient, round, factor and
//   accumulate steps for each polynomial term on the shared multiplier until
//   the result sits in the output register; s_axis_tready is low meanwhile.
//   A derivative above the order skips the scan and goes straight to the result.
// Reset: control and configuration return to defaults; memories are not cleared.
// Stall: a result waits in the output register; a following load word is
//   still taken, a following evaluate holds its result until the slot frees.
module piecewise_poly_derivative_eval_top
    import ppde_pkg::*;
#(
    parameter int NUM_POINTS = NUM_POINTS_DEF,
    parameter int MAX_ORDER  = MAX_ORDER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // slot_index, load_value, query_point
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,   // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // value, interval_used
    output logic [M_TUSER_W-1:0]  m_axis_tuser,   // status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    item_t   item;
    result_t core_res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    core_res_valid;

    assign item.cmd         = s_axis_tuser;
    assign item.slot_index  = s_axis_tdata[10:0];
    assign item.load_value  = s_axis_tdata[42:11];
    assign item.query_point = s_axis_tdata[74:43];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly_order  <= POLY_ORDER_RST;
            cfg_reg.deriv_order <= DERIV_ORDER_RST;
            cfg_reg.point_count <= POINT_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POLY_ORDER:  cfg_reg.poly_order  <= cfg_data[PORD_W-1:0];
                REG_DERIV_ORDER: cfg_reg.deriv_order <= cfg_data[DORD_W-1:0];
                REG_POINT_COUNT: cfg_reg.point_count <= cfg_data[PCNT_W-1:0];
                default:         ;
            endcase
        end
    end

    ppde_core #(
        .NUM_POINTS (NUM_POINTS),
        .MAX_ORDER  (MAX_ORDER)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item       (item),
        .res_valid  (core_res_valid),
        .out_free   (out_free),
        .res        (core_res)
    );

    // output word register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_res_valid && out_free)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_res_valid && out_free)
            out_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.interval_used, out_reg.value};
    assign m_axis_tuser  = out_reg.status;

endmodule

[hw/rtl/ppde_store.sv]
// Breakpoint and coefficient memories, one write port and one registered read port each.
// Depends on ppde_pkg.
module ppde_store
    import ppde_pkg::*;
#(
    parameter  int NUM_POINTS = NUM_POINTS_DEF,
    parameter  int MAX_ORDER  = MAX_ORDER_DEF,
    localparam int CF_DEPTH   = NUM_POINTS * (MAX_ORDER + 1),
    localparam int PAW        = $clog2(NUM_POINTS),
    localparam int CAW        = $clog2(CF_DEPTH)
)
(
    input  logic              clk,
    input  store_wr_t         wr,
    input  logic [PAW-1:0]    bp_raddr,
    input  logic [CAW-1:0]    cf_raddr,
    output logic [WORD_W-1:0] bp_rdata,
    output logic [WORD_W-1:0] cf_rdata
);

    logic [WORD_W-1:0] bp_mem [NUM_POINTS];
    logic [WORD_W-1:0] cf_mem [CF_DEPTH];

    logic bp_wen;
    logic cf_wen;

    // out-of-range slots are dropped
    assign bp_wen = wr.bp_we && (int'(wr.slot) < NUM_POINTS);
    assign cf_wen = wr.cf_we && (int'(wr.slot) < CF_DEPTH);

    always_ff @(posedge clk)
    begin
        if (bp_wen)
            bp_mem[PAW'(wr.slot)] <= wr.data;
        bp_rdata <= bp_mem[bp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cf_wen)
            cf_mem[CAW'(wr.slot)] <= wr.data;
        cf_rdata <= cf_mem[cf_raddr];
    end

endmodule

[hw/rtl/ppde_mul.sv]
// Shared signed 33x33 multiplier with a registered product.
// Depends on ppde_pkg.
module ppde_mul
    import ppde_pkg::*;
(
    input  logic                     clk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] prod
);

    always_ff @(posedge clk)
    begin
        prod <= req.a * req.b;
    end

endmodule

[hw/rtl/ppde_core.sv]
// Sequencer and datapath: interval scan, power chain and multiply-accumulate.
// Depends on ppde_pkg, ppde_store and ppde_mul.
module ppde_core
    import ppde_pkg::*;
#(
    parameter int NUM_POINTS = NUM_POINTS_DEF,
    parameter int MAX_ORDER  = MAX_ORDER_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    out_free,
    output result_t res
);

    localparam int CF_DEPTH = NUM_POINTS * (MAX_ORDER + 1);
    localparam int PAW      = $clog2(NUM_POINTS);
    localparam int CAW      = $clog2(CF_DEPTH);
    localparam int PCW      = $clog2(NUM_POINTS + 1);
    localparam int CW       = (PCW > PCNT_W) ? PCW : PCNT_W;
    localparam int JW       = $clog2(MAX_ORDER + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_SCAN = 11'b000_0000_0010,
        S_U    = 11'b000_0000_0100,
        S_LOAD = 11'b000_0000_1000,
        S_POW  = 11'b000_0001_0000,
        S_CMUL = 11'b000_0010_0000,
        S_RND  = 11'b000_0100_0000,
        S_FLO  = 11'b000_1000_0000,
        S_FHI  = 11'b001_0000_0000,
        S_ACC  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic              cmp_vld_reg, cmp_vld_next;
    logic [PCW-1:0]    iss_cnt_reg, iss_cnt_next;
    logic [PAW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [PAW-1:0]    ti_reg, ti_next;
    logic [WORD_W-1:0] tibp_reg, tibp_next;
    logic [WORD_W-1:0] x_reg, x_next;
    logic              err_reg, err_next;
    logic [WORD_W-1:0] u_reg, u_next;
    logic              pwc_reg, pwc_next;
    logic [WORD_W-1:0] pw_reg, pw_next;
    logic [JW-1:0]     j_reg, j_next;
    logic [CAW-1:0]    coef_addr_reg, coef_addr_next;
    logic [WORD_W-1:0] c_reg, c_next;
    logic [RND_W-1:0]  r_reg, r_next;
    logic [ACC_W-1:0]  lo_reg, lo_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              sat_reg, sat_next;

    store_wr_t         wr;
    mul_req_t          mreq;
    logic signed [PROD_W-1:0] prod;
    logic [WORD_W-1:0] bp_rdata;
    logic [WORD_W-1:0] cf_rdata;

    ppde_store #(
        .NUM_POINTS (NUM_POINTS),
        .MAX_ORDER  (MAX_ORDER)
    ) u_store (
        .clk      (clk),
        .wr       (wr),
        .bp_raddr (iss_cnt_reg[PAW-1:0]),
        .cf_raddr (coef_addr_reg),
        .bp_rdata (bp_rdata),
        .cf_rdata (cf_rdata)
    );

    ppde_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    // falling factorial table, indexed by power and derivative
    logic [FF_W-1:0] ff_rom [MAX_ORDER+1][FF_D];
    for (genvar gj = 0; gj <= MAX_ORDER; gj++)
    begin : g_ffj
        for (genvar gd = 0; gd < FF_D; gd++)
        begin : g_ffd
            assign ff_rom[gj][gd] = FF_W'(ff_calc(gj, gd));
        end
    end

    // effective configuration
    logic [CW-1:0]  cnt_ext;
    logic [PCW-1:0] n_eff;
    logic [JW-1:0]  p_eff;
    logic [JW-1:0]  j_init;
    logic           deriv_err;
    logic [JW:0]    p_plus1;
    logic [PAW+JW:0] base_mul;
    logic [CAW-1:0] coef_base;
    logic [FF_W-1:0] ff_cur;
    logic           j_gt_d;

    assign cnt_ext   = CW'(cfg.point_count);
    assign n_eff     = (cnt_ext == '0) ? PCW'(1) :
                       (cnt_ext > CW'(NUM_POINTS)) ? PCW'(NUM_POINTS) : PCW'(cnt_ext);
    assign p_eff     = (int'(cfg.poly_order) > MAX_ORDER) ? JW'(MAX_ORDER) : JW'(cfg.poly_order);
    assign deriv_err = int'(cfg.deriv_order) > int'(p_eff);
    assign j_init    = JW'(cfg.deriv_order);
    assign p_plus1   = {1'b0, p_eff} + 1'b1;
    assign base_mul  = {{(JW+1){1'b0}}, ti_reg} * {{PAW{1'b0}}, p_plus1};
    assign coef_base = CAW'(base_mul) + CAW'(j_init);
    assign ff_cur    = ff_rom[j_reg][cfg.deriv_order];
    assign j_gt_d    = (j_reg != j_init);

    // u = sat32(x - breakpoint)
    logic [WORD_W:0]   u_diff;
    logic              u_ovf;
    logic [WORD_W-1:0] u_sat;
    assign u_diff = {x_reg[WORD_W-1], x_reg} - {tibp_reg[WORD_W-1], tibp_reg};
    assign u_ovf  = u_diff[WORD_W] ^ u_diff[WORD_W-1];
    assign u_sat  = u_ovf ? (u_diff[WORD_W] ? WORD_MIN : WORD_MAX) : u_diff[WORD_W-1:0];

    logic [RND_W-1:0] pw_rnd;
    assign pw_rnd = rnd16(prod[ACC_W-1:0]);

    // term = ff * rnd, rebuilt from the low and high partial products
    logic [ACC_W-1:0]        term;
    logic signed [ACC_W:0]   acc_sum;
    assign term    = {prod[WORD_W-1:0], {WORD_W{1'b0}}} + lo_reg;
    assign acc_sum = $signed({acc_reg[ACC_W-1], acc_reg}) + $signed({term[ACC_W-1], term});

    logic              acc_ovf;
    logic [WORD_W-1:0] acc_sat;
    assign acc_ovf = !((&acc_reg[ACC_W-1:WORD_W-1]) || !(|acc_reg[ACC_W-1:WORD_W-1]));
    assign acc_sat = acc_ovf ? (acc_reg[ACC_W-1] ? WORD_MIN : WORD_MAX) : acc_reg[WORD_W-1:0];

    logic scan_issue;
    assign scan_issue = (iss_cnt_reg < n_eff);

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_FIN);

    assign wr.bp_we = item_valid && item_ready && (item.cmd == CMD_LOAD_BP);
    assign wr.cf_we = item_valid && item_ready && (item.cmd == CMD_LOAD_CF);
    assign wr.slot  = item.slot_index;
    assign wr.data  = item.load_value;

    always_comb
    begin
        res.value         = err_reg ? '0 : acc_sat;
        res.interval_used = err_reg ? '0 : IVL_W'(ti_reg);
        if (err_reg)
            res.status = STAT_DERIV;
        else if (sat_reg || acc_ovf)
            res.status = STAT_SAT;
        else
            res.status = STAT_OK;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmp_vld_next   = 1'b0;
        iss_cnt_next   = iss_cnt_reg;
        cmp_idx_next   = cmp_idx_reg;
        ti_next        = ti_reg;
        tibp_next      = tibp_reg;
        x_next         = x_reg;
        err_next       = err_reg;
        u_next         = u_reg;
        pwc_next       = pwc_reg;
        pw_next        = pw_reg;
        j_next         = j_reg;
        coef_addr_next = coef_addr_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        mreq.a         = '0;
        mreq.b         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && item.cmd == CMD_EVAL)
                begin
                    x_next       = item.query_point;
                    err_next     = deriv_err;
                    iss_cnt_next = '0;
                    state_next   = deriv_err ? S_FIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read at iss_cnt, compare the word read in the previous cycle
                if (scan_issue)
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                cmp_vld_next = scan_issue;
                cmp_idx_next = iss_cnt_reg[PAW-1:0];
                if (cmp_vld_reg &&
                    (cmp_idx_reg == '0 || $signed(bp_rdata) <= $signed(x_reg)))
                begin
                    ti_next   = cmp_idx_reg;
                    tibp_next = bp_rdata;
                end
                if (!scan_issue && !cmp_vld_reg)
                    state_next = S_U;
            end
            S_U:
            begin
                u_next         = u_sat;
                pwc_next       = u_ovf;
                pw_next        = ONE_Q16;
                j_next         = j_init;
                coef_addr_next = coef_base;
                acc_next       = '0;
                sat_next       = 1'b0;
                state_next     = S_LOAD;
            end
            S_LOAD:
            begin
                mreq.a     = {pw_reg[WORD_W-1], pw_reg};
                mreq.b     = {u_reg[WORD_W-1], u_reg};
                state_next = S_POW;
            end
            S_POW:
            begin
                if (j_gt_d)
                begin
                    pw_next = sat32_val(pw_rnd);
                    if (sat32_ovf(pw_rnd))
                        pwc_next = 1'b1;
                end
                c_next     = cf_rdata;
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                mreq.a = {c_reg[WORD_W-1], c_reg};
                mreq.b = {pw_reg[WORD_W-1], pw_reg};
                if (j_gt_d && pwc_reg && c_reg != '0)
                    sat_next = 1'b1;
                state_next = S_RND;
            end
            S_RND:
            begin
                r_next     = rnd16(prod[ACC_W-1:0]);
                state_next = S_FLO;
            end
            S_FLO:
            begin
                mreq.a     = {1'b0, ff_cur};
                mreq.b     = {1'b0, r_reg[WORD_W-1:0]};
                state_next = S_FHI;
            end
            S_FHI:
            begin
                lo_next    = prod[ACC_W-1:0];
                mreq.a     = {1'b0, ff_cur};
                mreq.b     = {{(MUL_W-RND_W+WORD_W){r_reg[RND_W-1]}}, r_reg[RND_W-1:WORD_W]};
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (acc_sum > ACC_POS)
                begin
                    acc_next = ACC_POS[ACC_W-1:0];
                    sat_next = 1'b1;
                end
                else if (acc_sum < ACC_NEG)
                begin
                    acc_next = ACC_NEG[ACC_W-1:0];
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_sum[ACC_W-1:0];
                end
                if (j_reg == p_eff)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    j_next         = j_reg + 1'b1;
                    coef_addr_next = coef_addr_reg + 1'b1;
                    state_next     = S_LOAD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_cnt_reg   <= iss_cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        ti_reg        <= ti_next;
        tibp_reg      <= tibp_next;
        x_reg         <= x_next;
        err_reg       <= err_next;
        u_reg         <= u_next;
        pwc_reg       <= pwc_next;
        pw_reg        <= pw_next;
        j_reg         <= j_next;
        coef_addr_reg <= coef_addr_next;
        c_reg         <= c_next;
        r_reg         <= r_next;
        lo_reg        <= lo_next;
        acc_reg       <= acc_next;
        sat_reg       <= sat_next;
    end

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !out_free) |=> (state_reg == S_FIN))
        else $error("result left before the output register was free");

    a_eval_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.cmd == CMD_EVAL && !deriv_err)
        |=> (state_reg == S_SCAN))
        else $error("evaluate word did not start the interval scan");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == S_SCAN))
        else $error("breakpoint compare pending outside the scan");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC)
        |=> ($signed({acc_reg[ACC_W-1], acc_reg}) <= ACC_POS &&
             $signed({acc_reg[ACC_W-1], acc_reg}) >= ACC_NEG))
        else $error("accumulator beyond its clamp");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the piecewise polynomial derivative evaluator.
// Streams table loads and evaluate words, predicts every result word and compares them.
// Depends on ppde_pkg and piecewise_poly_derivative_eval_top.
`timescale 1ns / 1ps

module tb_top;
    import ppde_pkg::*;

    localparam int     UNIT         = 65536;
    localparam int     COEF_DEPTH   = NUM_POINTS_DEF * (MAX_ORDER_DEF + 1);
    localparam int     HOLD_CYCLES  = 300;
    localparam int     QUIET_LIMIT  = 4000;
    localparam int     ITEM_TARGET  = 1050;
    localparam longint WORD_HI      = 64'sd2147483647;
    localparam longint WORD_LO      = -64'sd2147483648;
    localparam longint ACC_LIMIT    = 64'sh4000_0000_0000_0000;

    localparam logic [CMD_W-1:0]     CMD_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // slot_index, load_value, query_point
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;   // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // value, interval_used
    logic [M_TUSER_W-1:0]  m_axis_tuser;        // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    piecewise_poly_derivative_eval_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // shadow of the block's tables and registers, updated in acceptance order
    logic signed [WORD_W-1:0] spline_bp [NUM_POINTS_DEF];
    logic signed [WORD_W-1:0] spline_cf [COEF_DEPTH];
    logic [PORD_W-1:0]        cfg_order = POLY_ORDER_RST;
    logic [DORD_W-1:0]        cfg_deriv = DERIV_ORDER_RST;
    logic [PCNT_W-1:0]        cfg_count = POINT_COUNT_RST;

    item_t   pending_words [$];
    result_t expected_results [$];
    item_t   cur_word;
    int      words_queued = 0;
    int      words_taken = 0;
    int      counted_items = 0;
    int      results_seen = 0;
    int      error_count = 0;

    // stimulus-side plan of the current breakpoint table
    int      bp_plan [NUM_POINTS_DEF];
    int      bp_lo;
    int      bp_hi;

    function automatic int clamp_count(input int cnt);
        if (cnt < 1)
            return 1;
        if (cnt > NUM_POINTS_DEF)
            return NUM_POINTS_DEF;
        return cnt;
    endfunction

    function automatic longint clamp32(input longint v, inout bit hit);
        if (v > WORD_HI)
        begin
            hit = 1'b1;
            return WORD_HI;
        end
        if (v < WORD_LO)
        begin
            hit = 1'b1;
            return WORD_LO;
        end
        return v;
    endfunction

    // round half up of a Q32.32 product back to Q16.16
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic result_t eval_spline(input logic signed [WORD_W-1:0] x);
        result_t r;
        int      n, ti, j, k, p, d;
        longint  u, pw, acc, c, ff;
        bit      sat, pwc;
        r = '0;
        p = cfg_order;
        d = cfg_deriv;
        if (d > p)
        begin
            r.status = STAT_DERIV;
            return r;
        end
        n = clamp_count(cfg_count);
        ti = 0;
        for (k = 0; k < n; k++)
            if (spline_bp[k] <= x)
                ti = k;
        sat = 1'b0;
        pwc = 1'b0;
        u = clamp32(longint'(x) - longint'(spline_bp[ti]), pwc);
        pw = UNIT;
        acc = 0;
        for (j = d; j <= p; j++)
        begin
            c = longint'(spline_cf[ti * (p + 1) + j]);
            if (j > d)
                pw = clamp32(round_q16(pw * u), pwc);
            ff = 1;
            for (k = j; k > j - d; k--)
                ff = ff * k;
            acc = acc + ff * round_q16(c * pw);
            // a clamped power only matters where it meets a nonzero coefficient
            if (j > d && pwc && c != 0)
                sat = 1'b1;
            if (acc > ACC_LIMIT)
            begin
                acc = ACC_LIMIT;
                sat = 1'b1;
            end
            if (acc < -ACC_LIMIT)
            begin
                acc = -ACC_LIMIT;
                sat = 1'b1;
            end
        end
        acc = clamp32(acc, sat);
        r.value = acc[WORD_W-1:0];
        r.interval_used = ti[IVL_W-1:0];
        r.status = sat ? STAT_SAT : STAT_OK;
        return r;
    endfunction

    task automatic apply_word(input item_t w);
        case (w.cmd)
            CMD_LOAD_BP:
                if (w.slot_index < NUM_POINTS_DEF)
                    spline_bp[w.slot_index[7:0]] = w.load_value;
            CMD_LOAD_CF:
                spline_cf[w.slot_index] = w.load_value;
            CMD_EVAL:
                expected_results.push_back(eval_spline(w.query_point));
            default:
                ;
        endcase
    endtask

    // driver: presents pending words, random gap after each accepted word, with occasional gapless bursts
    int src_wait = 0;
    int src_burst = 0;

    always @(posedge clk)
    begin
        bit    fire;
        bit    next_valid;
        item_t w;
        if (rst_n)
        begin
            fire = s_axis_tvalid && s_axis_tready;
            next_valid = s_axis_tvalid && !fire;
            if (fire)
            begin
                apply_word(cur_word);
                words_taken++;
                if (src_burst > 0)
                begin
                    src_burst--;
                    src_wait = 0;
                end
                else
                begin
                    src_wait = $urandom_range(0, 11);
                    if ($urandom_range(0, 15) == 0)
                        src_burst = $urandom_range(20, 60);
                end
            end
            if (!next_valid)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    cur_word = w;
                    s_axis_tuser <= w.cmd;
                    s_axis_tdata <= {{(S_TDATA_W - SLOT_W - 2 * WORD_W){1'b0}},
                                     w.query_point, w.load_value, w.slot_index};
                    next_valid = 1'b1;
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    // monitor: compares result words, random back-pressure, one long hold
    int sink_wait = 0;
    int sink_burst = 0;
    bit hold_done = 1'b0;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, actual value %h status %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("value", $signed(want.value), $signed(m_axis_tdata[31:0]));
                    check_field("interval_used", want.interval_used, m_axis_tdata[39:32]);
                    check_field("status", want.status, m_axis_tuser);
                end
                results_seen++;
                if (!hold_done && results_seen >= 30 && pending_words.size() >= 8)
                begin
                    sink_wait = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                else if (sink_burst > 0)
                begin
                    sink_burst--;
                    sink_wait = 0;
                end
                else
                begin
                    sink_wait = $urandom_range(0, 11);
                    if ($urandom_range(0, 15) == 0)
                        sink_burst = $urandom_range(20, 60);
                end
            end
            else if (sink_wait > 0)
                sink_wait--;
            m_axis_tready <= (sink_wait == 0);
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [CMD_W-1:0] cmd, input int unsigned slot,
                             input logic [WORD_W-1:0] lv, input logic [WORD_W-1:0] x);
        item_t w;
        w.cmd = cmd;
        w.slot_index = slot[SLOT_W-1:0];
        w.load_value = lv;
        w.query_point = x;
        pending_words.push_back(w);
        words_queued++;
        if (cmd != CMD_NONE && !(cmd == CMD_LOAD_BP && slot >= NUM_POINTS_DEF))
            counted_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_POLY_ORDER:  cfg_order = data[PORD_W-1:0];
            REG_DERIV_ORDER: cfg_deriv = data[DORD_W-1:0];
            REG_POINT_COUNT: cfg_count = data[PCNT_W-1:0];
            default:         ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // all words taken and all results back, then let a trailing load settle
    task automatic drain();
        while (words_taken != words_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    function automatic int rand_coef();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return int'($urandom);
            2:       return int'($urandom_range(0, 512)) - 256;
            default: return int'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
        endcase
    endfunction

    function automatic int pick_query(input int n);
        longint span;
        bit     dummy;
        dummy = 1'b0;
        span = longint'(bp_hi) - longint'(bp_lo) + 4 * UNIT;
        case ($urandom_range(0, 19))
            0:           return int'(WORD_MIN);
            1:           return int'(WORD_MAX);
            2:           return 0;
            3, 4, 5:     return bp_plan[$urandom_range(0, n - 1)];
            6, 7, 8:     return int'($urandom);
            default:
                return int'(clamp32(longint'(bp_lo) - 2 * UNIT +
                                    longint'($urandom_range(0, span)), dummy));
        endcase
    endfunction

    // shape: 0 sorted, 1 sorted with repeats, 2 unsorted near zero, 3 any values
    task automatic load_table(input int n, input int p, input int shape);
        int k, base;
        base = int'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
        for (k = 0; k < n; k++)
        begin
            case (shape)
                0, 1:
                begin
                    if (k > 0)
                        base += (shape == 1 && $urandom_range(0, 2) == 0) ? 0 :
                                int'($urandom_range(UNIT / 4, 2 * UNIT));
                    bp_plan[k] = base;
                end
                2:       bp_plan[k] = int'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
                default: bp_plan[k] = int'($urandom);
            endcase
            push_word(CMD_LOAD_BP, k, bp_plan[k], $urandom);
        end
        if (shape <= 1)
        begin
            bp_lo = bp_plan[0];
            bp_hi = bp_plan[n - 1];
        end
        else
        begin
            bp_lo = -4 * UNIT;
            bp_hi = 4 * UNIT;
        end
        for (k = 0; k < n * (p + 1); k++)
            push_word(CMD_LOAD_CF, k, rand_coef(), $urandom);
    endtask

    task automatic run_phase(input int p, input int d, input int ncfg, input int shape,
                             input int words);
        int n, k;
        drain();
        write_reg(REG_POLY_ORDER, p);
        write_reg(REG_DERIV_ORDER, d);
        write_reg(REG_POINT_COUNT, ncfg);
        n = clamp_count(ncfg);
        load_table(n, p, shape);
        repeat (words)
        begin
            case ($urandom_range(0, 19))
                0:  push_word(CMD_NONE, $urandom_range(0, 2047), $urandom, $urandom);
                1:  push_word(CMD_LOAD_BP, $urandom_range(256, 2047), $urandom, $urandom);
                2:  push_word(CMD_LOAD_CF, $urandom_range(0, n * (p + 1) - 1), rand_coef(),
                              $urandom);
                3:  push_word(CMD_LOAD_CF, $urandom_range(0, 2047), $urandom, $urandom);
                4:
                begin
                    k = $urandom_range(0, n - 1);
                    bp_plan[k] = bp_plan[k] + int'($urandom_range(0, UNIT)) - UNIT / 2;
                    push_word(CMD_LOAD_BP, k, bp_plan[k], $urandom);
                end
                default:
                    push_word(CMD_EVAL, $urandom_range(0, 2047), $urandom, pick_query(n));
            endcase
        end
    endtask

    initial
    begin
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // four intervals of order two, edge queries and extreme coefficients
        write_reg(REG_POLY_ORDER, 2);
        write_reg(REG_DERIV_ORDER, 0);
        write_reg(REG_POINT_COUNT, 4);
        push_word(CMD_LOAD_BP, 0, -2 * UNIT, 0);
        push_word(CMD_LOAD_BP, 1, 0, 0);
        push_word(CMD_LOAD_BP, 2, UNIT, 0);
        push_word(CMD_LOAD_BP, 3, 3 * UNIT, 0);
        for (k = 0; k < 12; k++)
            push_word(CMD_LOAD_CF, k, (k - 5) * 8192, 0);
        push_word(CMD_LOAD_CF, 4, WORD_MAX, 0);
        push_word(CMD_LOAD_CF, 5, WORD_MAX, 0);
        push_word(CMD_LOAD_CF, 6, WORD_MIN, 0);
        push_word(CMD_EVAL, 0, 0, WORD_MIN);
        push_word(CMD_EVAL, 2047, 32'hFFFF_FFFF, WORD_MAX);
        push_word(CMD_EVAL, 0, 0, -3 * UNIT);
        push_word(CMD_EVAL, 0, 0, 0);
        push_word(CMD_EVAL, 0, 0, 32'h0000_F000);
        push_word(CMD_EVAL, 0, 0, UNIT);
        push_word(CMD_EVAL, 0, 0, 5 * UNIT);
        push_word(CMD_NONE, 2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(CMD_LOAD_BP, 2047, 32'hFFFF_FFFF, 0);
        // out of order table: the highest qualifying index wins
        push_word(CMD_LOAD_BP, 2, -3 * UNIT, 0);
        push_word(CMD_EVAL, 0, 0, -163840);
        push_word(CMD_EVAL, 0, 0, -2 * UNIT);

        // derivative above the order, plus a write to an unmapped register
        drain();
        write_reg(REG_DERIV_ORDER, 3);
        write_reg(REG_UNUSED, 9'h1FF);
        push_word(CMD_EVAL, 0, 0, WORD_MIN);
        push_word(CMD_EVAL, 0, 0, 0);

        // single interval at the top of the range, offset clamps low
        drain();
        write_reg(REG_POLY_ORDER, 7);
        write_reg(REG_DERIV_ORDER, 6);
        write_reg(REG_POINT_COUNT, 0);
        push_word(CMD_LOAD_BP, 0, WORD_MAX, 0);
        for (k = 0; k < 8; k++)
            push_word(CMD_LOAD_CF, k, (k + 1) * 4096, 0);
        push_word(CMD_EVAL, 0, 0, WORD_MIN);
        push_word(CMD_EVAL, 0, 0, 0);
        push_word(CMD_EVAL, 0, 0, WORD_MAX);
        push_word(CMD_EVAL, 0, 0, 32'h7FFF_0000);

        // full table, then the order extremes, then random settings
        run_phase(0, 0, 511, 0, 15);
        run_phase(7, 7, 2, 0, 20);
        run_phase(7, 0, 3, 0, 25);
        while (counted_items < ITEM_TARGET)
        begin
            int p, d, ncfg, shape;
            p = $urandom_range(0, 7);
            d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, p);
            case ($urandom_range(0, 9))
                0:       ncfg = 0;
                1:       ncfg = 1;
                default: ncfg = $urandom_range(2, 12);
            endcase
            shape = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
            run_phase(p, d, ncfg, shape, $urandom_range(20, 40));
        end

        drain();
        repeat (400) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ppde_pkg.sv
hw/rtl/ppde_store.sv
hw/rtl/ppde_mul.sv
hw/rtl/ppde_core.sv
hw/rtl/piecewise_poly_derivative_eval_top.sv
verif/tb_top.sv
